[sv/gfi_pkg.sv]
// Shared constants, types and helper functions for the GF(2^m) inverse block.
// Used by gfi_reduce, gfi_core and gf2m_inverse; depends on nothing else.
`default_nettype none

package gfi_pkg;

    localparam int FIELD_BITS = 10;
    localparam int MOD_BITS   = FIELD_BITS + 1;
    localparam int DEG_BITS   = $clog2(MOD_BITS);

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1033);

    typedef struct packed {
        logic [FIELD_BITS-1:0] inverse;
        logic                  has_inverse;
    } gfi_result_t;

    // Index of the highest set bit. A zero polynomial reads as degree zero,
    // so callers test for zero separately.
    function automatic logic [DEG_BITS-1:0] poly_degree(input logic [MOD_BITS-1:0] p);
        logic [DEG_BITS-1:0] d;
        d = '0;
        for (int i = 0; i < MOD_BITS; i++) begin
            if (p[i]) begin
                d = DEG_BITS'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[sv/gfi_reduce.sv]
// Shared shift-and-XOR unit: one carry-less long-division step on the
// remainder pair, applied to the cofactor pair with the same shift.
// Depends on gfi_pkg.
`default_nettype none

module gfi_reduce
    import gfi_pkg::*;
(
    input  wire logic [MOD_BITS-1:0]   r_prev,
    input  wire logic [FIELD_BITS-1:0] r_cur,
    input  wire logic [FIELD_BITS-1:0] w_prev,
    input  wire logic [FIELD_BITS-1:0] w_cur,
    output logic                       can_reduce,
    output logic [MOD_BITS-1:0]        r_prev_red,
    output logic [FIELD_BITS-1:0]      w_prev_red
);

    logic [MOD_BITS-1:0] r_cur_ext;
    logic [DEG_BITS-1:0] deg_prev;
    logic [DEG_BITS-1:0] deg_cur;
    logic [DEG_BITS-1:0] shift;

    assign r_cur_ext = {1'b0, r_cur};
    assign deg_prev  = poly_degree(r_prev);
    assign deg_cur   = poly_degree(r_cur_ext);
    assign shift     = deg_prev - deg_cur;

    // The divisor is never zero while this unit is in use.
    assign can_reduce = (r_prev != '0) && (deg_prev >= deg_cur);

    // Each quotient bit is folded into the cofactor at once, which gives the
    // same low bits as multiplying by the whole quotient afterwards.
    assign r_prev_red = r_prev ^ (r_cur_ext << shift);
    assign w_prev_red = w_prev ^ (w_cur << shift);

endmodule

`default_nettype wire

[sv/gfi_core.sv]
// Sequencer for the extended Euclidean inversion: holds the remainder and
// cofactor pairs and drives the shared reduce unit one step per cycle.
// Depends on gfi_pkg and gfi_reduce.
`default_nettype none

module gfi_core
    import gfi_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [FIELD_BITS-1:0] in_value,
    input  wire logic [MOD_BITS-1:0]   modulus,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output gfi_result_t                res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                state_reg, state_next;
    logic [MOD_BITS-1:0]   r_prev_reg, r_prev_next;
    logic [FIELD_BITS-1:0] r_cur_reg, r_cur_next;
    logic [FIELD_BITS-1:0] w_prev_reg, w_prev_next;
    logic [FIELD_BITS-1:0] w_cur_reg, w_cur_next;
    gfi_result_t           res_reg, res_next;

    logic                  can_reduce;
    logic [MOD_BITS-1:0]   r_prev_red;
    logic [FIELD_BITS-1:0] w_prev_red;

    gfi_reduce u_reduce (
        .r_prev     (r_prev_reg),
        .r_cur      (r_cur_reg),
        .w_prev     (w_prev_reg),
        .w_cur      (w_cur_reg),
        .can_reduce (can_reduce),
        .r_prev_red (r_prev_red),
        .w_prev_red (w_prev_red)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_HOLD);
    assign res       = res_reg;

    always_comb begin
        state_next  = state_reg;
        r_prev_next = r_prev_reg;
        r_cur_next  = r_cur_reg;
        w_prev_next = w_prev_reg;
        w_cur_next  = w_cur_reg;
        res_next    = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_value == '0) begin
                        res_next   = '{inverse: '0, has_inverse: 1'b0};
                        state_next = ST_HOLD;
                    end else if (in_value == FIELD_BITS'(1)) begin
                        res_next   = '{inverse: FIELD_BITS'(1), has_inverse: 1'b1};
                        state_next = ST_HOLD;
                    end else begin
                        r_prev_next = modulus;
                        r_cur_next  = in_value;
                        w_prev_next = '0;
                        w_cur_next  = FIELD_BITS'(1);
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (can_reduce) begin
                    r_prev_next = r_prev_red;
                    w_prev_next = w_prev_red;
                end else if (r_prev_reg == MOD_BITS'(1)) begin
                    res_next   = '{inverse: w_prev_reg, has_inverse: 1'b1};
                    state_next = ST_HOLD;
                end else if (r_prev_reg == '0) begin
                    res_next   = '{inverse: '0, has_inverse: 1'b0};
                    state_next = ST_HOLD;
                end else begin
                    // Division finished with a remainder of degree one or more:
                    // the divisor becomes the dividend for the next division.
                    r_prev_next = {1'b0, r_cur_reg};
                    r_cur_next  = r_prev_reg[FIELD_BITS-1:0];
                    w_prev_next = w_cur_reg;
                    w_cur_next  = w_prev_reg;
                end
            end
            ST_HOLD: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        r_prev_reg <= r_prev_next;
        r_cur_reg  <= r_cur_next;
        w_prev_reg <= w_prev_next;
        w_cur_reg  <= w_cur_next;
        res_reg    <= res_next;
    end

    // The divisor must never be zero while the division loop runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (r_cur_reg != '0))
        else $error("gfi_core: zero divisor during iteration");

    // A reduction step must lower the degree of the dividend.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && can_reduce) |=>
        (r_prev_reg == '0 || poly_degree(r_prev_reg) < poly_degree($past(r_prev_reg))))
        else $error("gfi_core: reduction did not lower the degree");

    // A failed inversion reports a zero inverse.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.has_inverse) |-> (res.inverse == '0))
        else $error("gfi_core: nonzero inverse without has_inverse");

    // An input of one is answered directly with inverse one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_value == FIELD_BITS'(1)) |=>
        (res_valid && res.has_inverse && res.inverse == FIELD_BITS'(1)))
        else $error("gfi_core: wrong result for an input of one");

endmodule

`default_nettype wire

[sv/gf2m_inverse.sv]
// Multiplicative inverse in GF(2^10) modulo a configurable polynomial.
// Top level: modulus register, output register and the gfi_core sequencer.
// Depends on gfi_pkg and gfi_core.
//
// Usage:
//   s_valid/s_ready/s_value carry one field element per transfer. The result
//   leaves on m_valid/m_ready as m_inverse and m_has_inverse; m_has_inverse
//   is low (and m_inverse zero) for a zero input or one that shares a factor
//   with the modulus.
//   cfg_valid/cfg_ready/cfg_modulus_poly write the reduction polynomial; the
//   port is always ready. Write it only while no inversion is in flight.
//   Timing, with m_ready high: a zero or one input is answered without the
//   division loop. Other inputs take one long-division step per cycle, with
//   a hand-over step between divisions and a final check to finish, and then
//   pass through the output register to m_valid. The core is ready again once
//   its result has moved on, so it works on one input at a time.
//   When m_ready is low the result waits in the output register while the
//   next input is worked; a second result waits in the core with s_ready low.
//   Reset (aresetn low, synchronous) empties both stages and loads the
//   modulus x^10 + x^3 + 1.
`default_nettype none

module gf2m_inverse
    import gfi_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FIELD_BITS-1:0] s_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [FIELD_BITS-1:0]      m_inverse,
    output logic                       m_has_inverse,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [MOD_BITS-1:0]   cfg_modulus_poly
);

    logic [MOD_BITS-1:0] modulus_reg;
    logic                m_valid_reg;
    gfi_result_t         out_reg;

    logic                res_valid;
    logic                res_ready;
    gfi_result_t         res;

    gfi_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .modulus   (modulus_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                modulus_reg <= cfg_modulus_poly;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inverse     = out_reg.inverse;
    assign m_has_inverse = out_reg.has_inverse;

endmodule

`default_nettype wire

[tb/gf2m_inverse_tb.sv]
// Self-checking testbench for gf2m_inverse: extended Euclidean inversion in GF(2^10).
// Needs gfi_pkg and the gf2m_inverse RTL; results are predicted inside this file.
`default_nettype none

module gf2m_inverse_tb;
    import gfi_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIVIDE_LIMIT = 2 * FIELD_BITS + 8;
    localparam int TAIL_CYCLES  = 2 * FIELD_BITS + 10;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FIELD_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [FIELD_BITS-1:0] m_inverse;
    logic                  m_has_inverse;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [MOD_BITS-1:0]   cfg_modulus_poly = MODULUS_RESET;

    gfi_result_t           expected_inverses[$];
    logic [MOD_BITS-1:0]   modulus_shadow = MODULUS_RESET;
    bit                    idle_on = 1'b1;
    int                    hold_request = 0;
    int                    cycle_count = 0;
    int                    error_count = 0;
    int                    values_sent = 0;
    int                    results_checked = 0;
    int                    inverses_found = 0;
    int                    modulus_writes = 0;

    gf2m_inverse dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inverse       (m_inverse),
        .m_has_inverse   (m_has_inverse),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_modulus_poly(cfg_modulus_poly)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_inverses.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Highest set bit, -1 for the zero polynomial.
    function automatic int poly_deg(logic [63:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++) begin
            if (p[i]) d = i;
        end
        return d;
    endfunction

    function automatic gfi_result_t predict_inverse(logic [FIELD_BITS-1:0] a,
                                                    logic [MOD_BITS-1:0] modulus);
        logic [63:0] r_prev, r_cur, w_prev, w_cur, quo, rem, w_next;
        int          den_deg, rem_deg;
        gfi_result_t res;
        res.inverse     = '0;
        res.has_inverse = 1'b0;
        if (a == FIELD_BITS'(1)) begin
            res.inverse     = FIELD_BITS'(1);
            res.has_inverse = 1'b1;
        end else if (a != '0) begin
            r_prev = 64'(modulus);
            r_cur  = 64'(a);
            w_prev = '0;
            w_cur  = 64'd1;
            for (int n = 0; n < DIVIDE_LIMIT; n++) begin
                quo     = '0;
                rem     = r_prev;
                den_deg = poly_deg(r_cur);
                rem_deg = poly_deg(rem);
                while (rem_deg >= den_deg) begin
                    quo     = quo ^ (64'd1 << (rem_deg - den_deg));
                    rem     = rem ^ (r_cur << (rem_deg - den_deg));
                    rem_deg = poly_deg(rem);
                end
                // Fold the quotient into the cofactor with a carry-less product.
                w_next = w_prev;
                for (int i = 0; i < 64; i++) begin
                    if (quo[i]) w_next = w_next ^ (w_cur << i);
                end
                if (rem <= 64'd1) begin
                    if (rem == 64'd1) begin
                        res.inverse     = w_next[FIELD_BITS-1:0];
                        res.has_inverse = 1'b1;
                    end
                    break;
                end
                r_prev = r_cur;
                r_cur  = rem;
                w_prev = w_cur;
                w_cur  = w_next;
            end
        end
        return res;
    endfunction

    // Result side: random stalls, an optional long hold, and the scoreboard check.
    initial begin
        int          stall_left;
        gfi_result_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_inverses.size() == 0) begin
                    $display("%0t: unexpected result, got inverse %h has_inverse %b",
                             $time, m_inverse, m_has_inverse);
                    error_count++;
                end else begin
                    want = expected_inverses.pop_front();
                    if (m_inverse !== want.inverse) begin
                        $display("%0t: inverse mismatch, expected %h, actual %h",
                                 $time, want.inverse, m_inverse);
                        error_count++;
                    end
                    if (m_has_inverse !== want.has_inverse) begin
                        $display("%0t: has_inverse mismatch, expected %b, actual %b",
                                 $time, want.has_inverse, m_has_inverse);
                        error_count++;
                    end
                    if (want.has_inverse) inverses_found++;
                end
            end
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_value(logic [FIELD_BITS-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        expected_inverses.push_back(predict_inverse(v, modulus_shadow));
        values_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge aclk);
    endtask

    task automatic write_modulus(logic [MOD_BITS-1:0] m);
        wait_drain();
        cfg_valid        <= 1'b1;
        cfg_modulus_poly <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        modulus_shadow  = m;
        modulus_writes++;
    endtask

    task automatic test_directed_values();
        // Reset modulus x^10 + x^3 + 1: zero, one, field extremes and bit patterns.
        send_value(10'h000);
        send_value(10'h001);
        send_value(10'h002);
        send_value(10'h003);
        send_value(10'h3FF);
        send_value(10'h200);
        send_value(10'h155);
        send_value(10'h2AA);
        wait_drain();
    endtask

    task automatic test_modulus_extremes();
        // x^10 is reducible: even inputs share the factor x.
        write_modulus(MOD_BITS'(1024));
        send_value(10'h002);
        send_value(10'h003);
        send_value(10'h3FF);
        send_value(10'h000);
        send_value(10'h001);
        // x^10 + 1 has the factor x + 1: inputs with an even number of terms have no inverse.
        write_modulus(MOD_BITS'(1025));
        send_value(10'h003);
        send_value(10'h3FF);
        send_value(10'h002);
        send_value(10'h200);
        write_modulus(MOD_BITS'(2047));
        send_value(10'h002);
        send_value(10'h3FF);
        send_value(10'h000);
        send_value(10'h001);
        wait_drain();
    endtask

    task automatic test_backpressure();
        idle_on      = 1'b0;
        write_modulus(MODULUS_RESET);
        hold_request = 120;
        repeat (12) send_value(FIELD_BITS'($urandom_range(0, 1023)));
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_pause_between_bursts();
        repeat (4) begin
            repeat ($urandom_range(2, 6)) send_value(FIELD_BITS'($urandom_range(0, 1023)));
            wait_drain();
            @(posedge aclk);
        end
    endtask

    task automatic test_random_values();
        logic [MOD_BITS-1:0]   modulus;
        logic [FIELD_BITS-1:0] v;
        int                    pick;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: modulus = MOD_BITS'(1024);
                1: modulus = MOD_BITS'(2047);
                2: modulus = MODULUS_RESET;
                default: modulus = MOD_BITS'($urandom_range(1024, 2047));
            endcase
            // The last phase runs with both sides at full rate.
            if (phase == 8) idle_on = 1'b0;
            write_modulus(modulus);
            repeat (140) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    v = FIELD_BITS'($urandom_range(0, 3));
                end else if (pick == 1) begin
                    v = FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1);
                end else begin
                    v = FIELD_BITS'($urandom_range(0, 1023));
                end
                send_value(v);
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_values();
        test_modulus_extremes();
        test_backpressure();
        test_pause_between_bursts();
        test_random_values();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d field elements under %0d modulus settings.", values_sent,
                 modulus_writes + 1);
        $display("Checked %0d results, %0d of them with an inverse.", results_checked,
                 inverses_found);
        if (error_count == 0 && expected_inverses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
